@@ design/srsa_pkg.sv @@
// srsa_pkg: shared widths, register codes, reset values and the config bundle
// for the step-response settling analyzer. No dependencies.
`default_nettype none

package srsa_pkg;

    localparam int SAMPLE_BITS_DEF = 32;
    localparam int INDEX_BITS_DEF  = 32;

    localparam int THR_W      = 31;
    localparam int BAND_W     = 16;
    localparam int MIN_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam int OUT_CNT_W = 32;
    localparam int OVS_W     = 16;

    // overshoot scale 100 * 256 = 25600 = 25 << 10
    localparam int PCT_SHIFT     = 10;
    localparam int QUOT_W        = 17;
    localparam int DIV_PRE_SHIFT = QUOT_W - PCT_SHIFT;

    localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_FRACTION      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SETTLE_SAMPLES = 2'd2;

    localparam logic [THR_W-1:0]  THR_RESET  = 31'd1;
    localparam logic [BAND_W-1:0] BAND_RESET = 16'd1311;
    localparam logic [MIN_W-1:0]  MIN_RESET  = 8'd5;

    localparam logic [OVS_W-1:0] OVS_SAT = '1;

    typedef struct packed {
        logic [THR_W-1:0]  change_threshold;
        logic [BAND_W-1:0] band_fraction;
        logic [MIN_W-1:0]  min_settle_samples;
    } cfg_t;

endpackage

`default_nettype wire

@@ design/srsa_front.sv @@
// srsa_front: accepts sample words, tags them with index and first-sample flag,
// flags setpoint moves and pushes them to the queue. Uses srsa_pkg.
`default_nettype none

module srsa_front #(
    parameter int SAMPLE_BITS = srsa_pkg::SAMPLE_BITS_DEF,
    parameter int INDEX_BITS  = srsa_pkg::INDEX_BITS_DEF,
    parameter int ENTRY_W     = 3 * SAMPLE_BITS + INDEX_BITS + 3
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_stall,
    input  wire signed [SAMPLE_BITS-1:0] setpoint,
    input  wire signed [SAMPLE_BITS-1:0] measured,
    input  wire                          last_sample,
    input  srsa_pkg::cfg_t               cfg,
    input  wire                          q_full,
    output logic                         q_push,
    output logic [ENTRY_W-1:0]           q_data
);

    localparam int SDW = SAMPLE_BITS + 1;
    localparam int DW  = (SAMPLE_BITS + 2 > srsa_pkg::THR_W + 2) ?
                         SAMPLE_BITS + 2 : srsa_pkg::THR_W + 2;

    logic signed [SAMPLE_BITS-1:0] prev_sp_reg;
    logic signed [SAMPLE_BITS-1:0] prev_cv_reg;
    logic [INDEX_BITS-1:0]         idx_reg;
    logic                          primed_reg;

    logic                 accept;
    logic signed [SDW-1:0] sp_diff;
    logic signed [DW-1:0]  diff_w;
    logic signed [DW-1:0]  thr_w;
    logic signed [DW-1:0]  diff_plus_thr;
    logic                  moved;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept;

    // |sp - prev| > thr  <=>  diff > thr  or  diff + thr < 0
    assign sp_diff       = SDW'(setpoint) - SDW'(prev_sp_reg);
    assign diff_w        = DW'(sp_diff);
    assign thr_w         = signed'(DW'(cfg.change_threshold));
    assign diff_plus_thr = diff_w + thr_w;
    assign moved         = primed_reg && ((diff_w > thr_w) || diff_plus_thr[DW-1]);

    assign q_data = {last_sample, moved, primed_reg, idx_reg, prev_cv_reg, measured, setpoint};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            primed_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (last_sample)
            begin
                idx_reg    <= '0;
                primed_reg <= 1'b0;
            end
            else
            begin
                idx_reg    <= idx_reg + 1'b1;
                primed_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prev_sp_reg <= setpoint;
            prev_cv_reg <= measured;
        end
    end

endmodule

`default_nettype wire

@@ design/srsa_queue.sv @@
// srsa_queue: two-word queue between front and back of the settling analyzer.
// No package dependencies.
`default_nettype none

module srsa_queue #(
    parameter int WIDTH = 32
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  wire [WIDTH-1:0]  push_data,
    output logic             full,
    input  wire              pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign full     = (count_reg == (PTR_W + 1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full) else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty) else $error("queue pop while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PTR_W + 1)'(DEPTH)) else $error("queue count out of range");

endmodule

`default_nettype wire

@@ design/srsa_back.sv @@
// srsa_back: sequencer that runs the step test per word: open/peak update,
// shift-add band check, serial overshoot divide, result register. Uses srsa_pkg.
`default_nettype none

module srsa_back #(
    parameter int SAMPLE_BITS = srsa_pkg::SAMPLE_BITS_DEF,
    parameter int INDEX_BITS  = srsa_pkg::INDEX_BITS_DEF,
    parameter int ENTRY_W     = 3 * SAMPLE_BITS + INDEX_BITS + 3
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  srsa_pkg::cfg_t                     cfg,
    input  wire                                q_empty,
    input  wire [ENTRY_W-1:0]                  q_data,
    output logic                               q_pop,
    output logic                               out_valid,
    input  wire                                out_stall,
    output logic [srsa_pkg::OUT_CNT_W-1:0]     settling_samples,
    output logic [srsa_pkg::OUT_CNT_W-1:0]     rise_time_tenths,
    output logic [srsa_pkg::OVS_W-1:0]         overshoot_pct,
    output logic                               settled_seen
);

    localparam int SB     = SAMPLE_BITS;
    localparam int IB     = INDEX_BITS;
    localparam int SDW    = SB + 1;
    localparam int SPW    = (SB + 2 > srsa_pkg::THR_W + 2) ? SB + 2 : srsa_pkg::THR_W + 2;
    localparam int SMW    = SPW - 1;
    localparam int ACC_W  = SMW + srsa_pkg::BAND_W;
    localparam int TCW    = (SDW > srsa_pkg::THR_W) ? SDW : srsa_pkg::THR_W;
    localparam int D3W    = SDW + 2;
    localparam int A25_W  = SDW + 5;
    localparam int REM_W  = SDW + 1;
    localparam int QW     = srsa_pkg::QUOT_W;
    localparam int CNT_W  = $clog2(QW);
    localparam int OCW    = srsa_pkg::OUT_CNT_W;
    localparam int RTW    = (IB + 2 > OCW + 1) ? IB + 2 : OCW + 1;
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(srsa_pkg::BAND_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QW - 1);

    typedef enum logic [8:0] {
        S_IDLE = 9'b0_0000_0001,
        S_OPEN = 9'b0_0000_0010,
        S_SPAN = 9'b0_0000_0100,
        S_MAG  = 9'b0_0000_1000,
        S_MUL  = 9'b0_0001_0000,
        S_CMP  = 9'b0_0010_0000,
        S_OVS  = 9'b0_0100_0000,
        S_DIV  = 9'b0_1000_0000,
        S_DONE = 9'b1_0000_0000
    } state_t;

    // control
    state_t                        state_reg, state_next;
    logic                          open_reg, open_next;
    logic                          any_settled_reg, any_settled_next;
    logic [IB-1:0]                 held_settle_reg, held_settle_next;
    logic [srsa_pkg::OVS_W-1:0]    held_ovs_reg, held_ovs_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          out_valid_reg, out_valid_next;

    // payload
    logic signed [SB-1:0]          it_sp_reg, it_sp_next;
    logic signed [SB-1:0]          it_cv_reg, it_cv_next;
    logic signed [SB-1:0]          it_pcv_reg, it_pcv_next;
    logic [IB-1:0]                 it_idx_reg, it_idx_next;
    logic                          it_primed_reg, it_primed_next;
    logic                          it_moved_reg, it_moved_next;
    logic                          it_last_reg, it_last_next;
    logic [IB-1:0]                 start_idx_reg, start_idx_next;
    logic signed [SB-1:0]          step_sp_reg, step_sp_next;
    logic signed [SB-1:0]          start_val_reg, start_val_next;
    logic signed [SB-1:0]          peak_reg, peak_next;
    logic [SDW-1:0]                err_reg, err_next;
    logic signed [SPW-1:0]         span_sum_reg, span_sum_next;
    logic [IB-1:0]                 dist_reg, dist_next;
    logic [ACC_W-1:0]              mcand_reg, mcand_next;
    logic [ACC_W-1:0]              acc_reg, acc_next;
    logic [srsa_pkg::BAND_W-1:0]   band_sh_reg, band_sh_next;
    logic [SDW-1:0]                dsp_reg, dsp_next;
    logic [SDW-1:0]                aov_reg, aov_next;
    logic [REM_W-1:0]              rem_reg, rem_next;
    logic [QW-1:0]                 nlow_reg, nlow_next;
    logic [QW-1:0]                 quot_reg, quot_next;
    logic [OCW-1:0]                settle_out_reg, settle_out_next;
    logic [OCW-1:0]                rise_out_reg, rise_out_next;
    logic [srsa_pkg::OVS_W-1:0]    ovs_out_reg, ovs_out_next;
    logic                          seen_out_reg, seen_out_next;

    // datapath
    logic signed [SB-1:0]  e_sp, e_cv, e_pcv;
    logic [IB-1:0]         e_idx;
    logic                  e_primed, e_moved, e_last;
    logic signed [SDW-1:0] cv_sp_diff;
    logic [SDW-1:0]        err_mag;
    logic [SMW-1:0]        span_mag;
    logic signed [SDW-1:0] dsp_diff;
    logic [SDW-1:0]        dsp_mag;
    logic signed [SDW-1:0] pk_diff;
    logic [SDW-1:0]        pk_mag;
    logic [ACC_W-1:0]      err_scaled;
    logic                  close_test;
    logic [D3W-1:0]        dsp3;
    logic [A25_W-1:0]      a25;
    logic [REM_W-1:0]      div_trial;
    logic                  div_ge;
    logic [QW-1:0]         quot_shift;
    logic [RTW-1:0]        settle_w;
    logic [RTW-1:0]        rise_w;
    logic                  out_free;

    assign e_sp     = q_data[SB-1:0];
    assign e_cv     = q_data[2*SB-1:SB];
    assign e_pcv    = q_data[3*SB-1:2*SB];
    assign e_idx    = q_data[3*SB+IB-1:3*SB];
    assign e_primed = q_data[3*SB+IB];
    assign e_moved  = q_data[3*SB+IB+1];
    assign e_last   = q_data[3*SB+IB+2];

    assign cv_sp_diff = SDW'(it_cv_reg) - SDW'(it_sp_reg);
    assign err_mag    = cv_sp_diff[SDW-1] ? SDW'(-cv_sp_diff) : SDW'(cv_sp_diff);
    assign span_mag   = span_sum_reg[SPW-1] ? SMW'(-span_sum_reg) : SMW'(span_sum_reg);
    assign dsp_diff   = SDW'(step_sp_reg) - SDW'(start_val_reg);
    assign dsp_mag    = dsp_diff[SDW-1] ? SDW'(-dsp_diff) : SDW'(dsp_diff);
    assign pk_diff    = SDW'(peak_reg) - SDW'(step_sp_reg);
    assign pk_mag     = pk_diff[SDW-1] ? SDW'(-pk_diff) : SDW'(pk_diff);

    // err * 2^16 < band * span
    assign err_scaled = ACC_W'(err_reg) << srsa_pkg::BAND_W;
    assign close_test = (err_scaled < acc_reg) &&
                        (dist_reg > IB'(cfg.min_settle_samples));

    assign dsp3 = D3W'(dsp_reg) + (D3W'(dsp_reg) << 1);
    // x25
    assign a25  = (A25_W'(aov_reg) << 4) + (A25_W'(aov_reg) << 3) + A25_W'(aov_reg);

    assign div_trial  = {rem_reg[REM_W-2:0], nlow_reg[QW-1]};
    assign div_ge     = (div_trial >= REM_W'(dsp_reg));
    assign quot_shift = {quot_reg[QW-2:0], div_ge};

    assign settle_w = RTW'(held_settle_reg);
    assign rise_w   = RTW'(held_settle_reg) + (RTW'(held_settle_reg) << 1);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next       = state_reg;
        open_next        = open_reg;
        any_settled_next = any_settled_reg;
        held_settle_next = held_settle_reg;
        held_ovs_next    = held_ovs_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg;
        it_sp_next       = it_sp_reg;
        it_cv_next       = it_cv_reg;
        it_pcv_next      = it_pcv_reg;
        it_idx_next      = it_idx_reg;
        it_primed_next   = it_primed_reg;
        it_moved_next    = it_moved_reg;
        it_last_next     = it_last_reg;
        start_idx_next   = start_idx_reg;
        step_sp_next     = step_sp_reg;
        start_val_next   = start_val_reg;
        peak_next        = peak_reg;
        err_next         = err_reg;
        span_sum_next    = span_sum_reg;
        dist_next        = dist_reg;
        mcand_next       = mcand_reg;
        acc_next         = acc_reg;
        band_sh_next     = band_sh_reg;
        dsp_next         = dsp_reg;
        aov_next         = aov_reg;
        rem_next         = rem_reg;
        nlow_next        = nlow_reg;
        quot_next        = quot_reg;
        settle_out_next  = settle_out_reg;
        rise_out_next    = rise_out_reg;
        ovs_out_next     = ovs_out_reg;
        seen_out_next    = seen_out_reg;
        q_pop            = 1'b0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop          = 1'b1;
                    it_sp_next     = e_sp;
                    it_cv_next     = e_cv;
                    it_pcv_next    = e_pcv;
                    it_idx_next    = e_idx;
                    it_primed_next = e_primed;
                    it_moved_next  = e_moved;
                    it_last_next   = e_last;
                    state_next     = S_OPEN;
                end
            end
            S_OPEN:
            begin
                err_next = err_mag;
                if (it_primed_reg && !open_reg && it_moved_reg)
                begin
                    open_next      = 1'b1;
                    start_idx_next = it_idx_reg;
                    step_sp_next   = it_sp_reg;
                    start_val_next = it_pcv_reg;
                    peak_next      = it_cv_reg;
                end
                else if (it_primed_reg && open_reg && (it_cv_reg > peak_reg))
                    peak_next = it_cv_reg;
                if (it_primed_reg && (open_reg || it_moved_reg))
                    state_next = S_SPAN;
                else
                    state_next = S_DONE;
            end
            S_SPAN:
            begin
                span_sum_next = SPW'(it_sp_reg) - SPW'(start_val_reg) +
                                signed'(SPW'(cfg.change_threshold));
                dist_next     = it_idx_reg - start_idx_reg;
                state_next    = S_MAG;
            end
            S_MAG:
            begin
                mcand_next   = ACC_W'(span_mag);
                acc_next     = '0;
                band_sh_next = cfg.band_fraction;
                cnt_next     = '0;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                if (band_sh_reg[0])
                    acc_next = acc_reg + mcand_reg;
                mcand_next   = mcand_reg << 1;
                band_sh_next = band_sh_reg >> 1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST)
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                if (close_test)
                begin
                    open_next        = 1'b0;
                    held_settle_next = dist_reg;
                    any_settled_next = 1'b1;
                    dsp_next         = dsp_mag;
                    aov_next         = pk_mag;
                    state_next       = S_OVS;
                end
                else
                    state_next = S_DONE;
            end
            S_OVS:
            begin
                if (TCW'(dsp_reg) > TCW'(cfg.change_threshold))
                begin
                    if (D3W'(aov_reg) >= dsp3)
                    begin
                        held_ovs_next = srsa_pkg::OVS_SAT;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        rem_next   = REM_W'(a25 >> srsa_pkg::DIV_PRE_SHIFT);
                        nlow_next  = {a25[srsa_pkg::DIV_PRE_SHIFT-1:0],
                                      srsa_pkg::PCT_SHIFT'(0)};
                        quot_next  = '0;
                        cnt_next   = '0;
                        state_next = S_DIV;
                    end
                end
                else
                begin
                    held_ovs_next = '0;
                    state_next    = S_DONE;
                end
            end
            S_DIV:
            begin
                rem_next  = div_ge ? div_trial - REM_W'(dsp_reg) : div_trial;
                quot_next = quot_shift;
                nlow_next = nlow_reg << 1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    held_ovs_next = quot_shift[QW-1] ? srsa_pkg::OVS_SAT :
                                    quot_shift[srsa_pkg::OVS_W-1:0];
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!it_last_reg)
                    state_next = S_IDLE;
                else if (out_free)
                begin
                    settle_out_next  = (|settle_w[RTW-1:OCW]) ? '1 : settle_w[OCW-1:0];
                    rise_out_next    = (|rise_w[RTW-1:OCW]) ? '1 : rise_w[OCW-1:0];
                    ovs_out_next     = held_ovs_reg;
                    seen_out_next    = any_settled_reg;
                    out_valid_next   = 1'b1;
                    open_next        = 1'b0;
                    any_settled_next = 1'b0;
                    held_settle_next = '0;
                    held_ovs_next    = '0;
                    state_next       = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            open_reg        <= 1'b0;
            any_settled_reg <= 1'b0;
            held_settle_reg <= '0;
            held_ovs_reg    <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            open_reg        <= open_next;
            any_settled_reg <= any_settled_next;
            held_settle_reg <= held_settle_next;
            held_ovs_reg    <= held_ovs_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        it_sp_reg      <= it_sp_next;
        it_cv_reg      <= it_cv_next;
        it_pcv_reg     <= it_pcv_next;
        it_idx_reg     <= it_idx_next;
        it_primed_reg  <= it_primed_next;
        it_moved_reg   <= it_moved_next;
        it_last_reg    <= it_last_next;
        start_idx_reg  <= start_idx_next;
        step_sp_reg    <= step_sp_next;
        start_val_reg  <= start_val_next;
        peak_reg       <= peak_next;
        err_reg        <= err_next;
        span_sum_reg   <= span_sum_next;
        dist_reg       <= dist_next;
        mcand_reg      <= mcand_next;
        acc_reg        <= acc_next;
        band_sh_reg    <= band_sh_next;
        dsp_reg        <= dsp_next;
        aov_reg        <= aov_next;
        rem_reg        <= rem_next;
        nlow_reg       <= nlow_next;
        quot_reg       <= quot_next;
        settle_out_reg <= settle_out_next;
        rise_out_reg   <= rise_out_next;
        ovs_out_reg    <= ovs_out_next;
        seen_out_reg   <= seen_out_next;
    end

    assign out_valid        = out_valid_reg;
    assign settling_samples = settle_out_reg;
    assign rise_time_tenths = rise_out_reg;
    assign overshoot_pct    = ovs_out_reg;
    assign settled_seen     = seen_out_reg;

    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < REM_W'(dsp_reg)))
        else $error("divider remainder not below divisor");

    a_close_updates: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP && close_test) |=> (!open_reg && any_settled_reg))
        else $error("closed test left open or not recorded");

    a_result_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE && it_last_reg))
        else $error("result word without a last sample");

endmodule

`default_nettype wire

@@ design/step_response_settling_analyzer_core.sv @@
// Sequence: each popped word runs the open/peak update; with a test open it then runs
// span, a 16-step band multiply and the close test, and a closing test can add a 17-step divide.
// The back-end sequencer handles one word at a time and pops the next only when done;
// a two-word queue lets the input take words while the back end works.
// Reset: async active low; config returns to defaults, state and queue clear.
`default_nettype none

module step_response_settling_analyzer_core #(
    parameter int SAMPLE_BITS = srsa_pkg::SAMPLE_BITS_DEF,
    parameter int INDEX_BITS  = srsa_pkg::INDEX_BITS_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_stall,
    input  wire signed [SAMPLE_BITS-1:0]      setpoint,
    input  wire signed [SAMPLE_BITS-1:0]      measured,
    input  wire                               last_sample,
    output logic                              out_valid,
    input  wire                               out_stall,
    output logic [srsa_pkg::OUT_CNT_W-1:0]    settling_samples,
    output logic [srsa_pkg::OUT_CNT_W-1:0]    rise_time_tenths,
    output logic [srsa_pkg::OVS_W-1:0]        overshoot_pct,
    output logic                              settled_seen,
    input  wire                               cfg_we,
    input  wire [srsa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [srsa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int ENTRY_W = 3 * SAMPLE_BITS + INDEX_BITS + 3;

    srsa_pkg::cfg_t     cfg_reg;
    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    logic [ENTRY_W-1:0] q_wdata;
    logic [ENTRY_W-1:0] q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.change_threshold   <= srsa_pkg::THR_RESET;
            cfg_reg.band_fraction      <= srsa_pkg::BAND_RESET;
            cfg_reg.min_settle_samples <= srsa_pkg::MIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                srsa_pkg::REG_CHANGE_THRESHOLD:
                    cfg_reg.change_threshold <= cfg_wdata[srsa_pkg::THR_W-1:0];
                srsa_pkg::REG_BAND_FRACTION:
                    cfg_reg.band_fraction <= cfg_wdata[srsa_pkg::BAND_W-1:0];
                srsa_pkg::REG_MIN_SETTLE_SAMPLES:
                    cfg_reg.min_settle_samples <= cfg_wdata[srsa_pkg::MIN_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    srsa_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .INDEX_BITS  (INDEX_BITS),
        .ENTRY_W     (ENTRY_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .setpoint    (setpoint),
        .measured    (measured),
        .last_sample (last_sample),
        .cfg         (cfg_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_wdata)
    );

    srsa_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    srsa_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .INDEX_BITS  (INDEX_BITS),
        .ENTRY_W     (ENTRY_W)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .q_empty          (q_empty),
        .q_data           (q_rdata),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .settling_samples (settling_samples),
        .rise_time_tenths (rise_time_tenths),
        .overshoot_pct    (overshoot_pct),
        .settled_seen     (settled_seen)
    );

endmodule

`default_nettype wire

@@ test/tb_step_response_settling_analyzer_core.sv @@
// Testbench for step_response_settling_analyzer_core: directed step series, then random
// damped step responses and noise under several register settings and handshake loads.
// Depends on srsa_pkg and the core; results are checked against an in-bench predictor.
module tb_step_response_settling_analyzer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import srsa_pkg::*;

    typedef struct packed {
        logic [31:0] settling;
        logic [31:0] rise;
        logic [15:0] overshoot;
        logic        seen;
    } settle_report_t;

    typedef struct {
        logic signed [31:0] sp;
        logic signed [31:0] cv;
        bit                 last;
        bit                 pinned;
        settle_report_t     want;
    } stim_row_t;

    localparam settle_report_t NO_REPORT = '0;
    localparam logic signed [31:0] ONE  = 32'sd65536;
    localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SMIN = 32'sh8000_0000;
    localparam int DRAIN_CYCLES = 200;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [31:0]       setpoint;
    logic signed [31:0]       measured;
    logic                     last_sample;
    logic                     out_valid;
    logic                     out_stall;
    logic [OUT_CNT_W-1:0]     settling_samples;
    logic [OUT_CNT_W-1:0]     rise_time_tenths;
    logic [OVS_W-1:0]         overshoot_pct;
    logic                     settled_seen;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_wdata;

    step_response_settling_analyzer_core i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .setpoint         (setpoint),
        .measured         (measured),
        .last_sample      (last_sample),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .settling_samples (settling_samples),
        .rise_time_tenths (rise_time_tenths),
        .overshoot_pct    (overshoot_pct),
        .settled_seen     (settled_seen),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    // register copy
    logic [THR_W-1:0]  thr_q;
    logic [BAND_W-1:0] band_q;
    logic [MIN_W-1:0]  min_q;

    // series state
    logic signed [31:0] last_sp;
    logic signed [31:0] last_cv;
    logic signed [31:0] tst_sp;
    logic signed [31:0] tst_start;
    logic signed [31:0] tst_peak;
    logic [31:0]        idx_q;
    logic [31:0]        tst_idx;
    logic [31:0]        hold_settle;
    logic [15:0]        hold_ovs;
    bit                 tst_open;
    bit                 saw_settle;
    bit                 primed_q;

    settle_report_t settle_reports[$];
    int             mismatches = 0;
    int             words_sent = 0;
    int             idle_pct = 0;
    int             stall_pct = 0;

    stim_row_t step_script [22] = '{
        '{32'sd0, 32'sd0, 1'b1, 1'b1, NO_REPORT},
        '{32'sd0, 32'sd0, 1'b0, 1'b0, NO_REPORT},
        '{ONE, 32'sd0, 1'b0, 1'b0, NO_REPORT},
        '{ONE, 32'sd80000, 1'b0, 1'b0, NO_REPORT},
        '{ONE, 32'sd70000, 1'b0, 1'b0, NO_REPORT},
        '{ONE, ONE, 1'b0, 1'b0, NO_REPORT},
        '{SMIN, ONE, 1'b0, 1'b0, NO_REPORT},
        '{ONE, ONE, 1'b0, 1'b0, NO_REPORT},
        '{ONE, ONE, 1'b1, 1'b0, NO_REPORT},
        '{SMAX, SMIN, 1'b0, 1'b0, NO_REPORT},
        '{SMIN, SMAX, 1'b0, 1'b0, NO_REPORT},
        '{SMIN, SMIN, 1'b1, 1'b0, NO_REPORT},
        '{32'sd0, 32'sd0, 1'b0, 1'b0, NO_REPORT},
        '{2 * ONE, SMAX, 1'b0, 1'b0, NO_REPORT},
        '{2 * ONE, 2 * ONE, 1'b0, 1'b0, NO_REPORT},
        '{2 * ONE, 2 * ONE, 1'b0, 1'b0, NO_REPORT},
        '{2 * ONE, 2 * ONE, 1'b0, 1'b0, NO_REPORT},
        '{2 * ONE, 2 * ONE, 1'b0, 1'b0, NO_REPORT},
        '{2 * ONE, 2 * ONE, 1'b0, 1'b0, NO_REPORT},
        '{2 * ONE, 2 * ONE, 1'b1, 1'b1, '{32'd6, 32'd18, 16'hFFFF, 1'b1}},
        '{32'sd5, 32'sd5, 1'b0, 1'b0, NO_REPORT},
        '{32'sd5, -32'sd5, 1'b1, 1'b1, NO_REPORT}
    };

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge clk)
    begin
        out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end

    function automatic logic [63:0] abs_val(input longint d);
        return (d < 0) ? 64'(-d) : 64'(d);
    endfunction

    function automatic logic signed [31:0] sat32(input longint v);
        if (v > longint'(SMAX))
            return SMAX;
        if (v < longint'(SMIN))
            return SMIN;
        return v[31:0];
    endfunction

    // err * 65536 < band * span without a wide product
    function automatic bit within_band(input logic [63:0] err, input logic [63:0] span);
        logic [63:0] t;
        logic [63:0] d;
        t = 64'(band_q) * (span >> 16);
        if (err < t)
            return 1'b1;
        d = err - t;
        if (d >= 64'd65536)
            return 1'b0;
        return (d << 16) < 64'(band_q) * (span & 64'hFFFF);
    endfunction

    // floor(a * 25600 / d), saturating
    function automatic logic [15:0] overshoot_q88(input logic [63:0] a, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] v;
        q = a / d;
        if (q >= 64'd3)
            return 16'hFFFF;
        v = q * 64'd25600 + ((a % d) * 64'd25600) / d;
        return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic void clear_series();
        last_sp = '0;
        last_cv = '0;
        idx_q = '0;
        tst_open = 1'b0;
        tst_idx = '0;
        tst_sp = '0;
        tst_start = '0;
        tst_peak = '0;
        hold_settle = '0;
        hold_ovs = '0;
        saw_settle = 1'b0;
        primed_q = 1'b0;
    endfunction

    function automatic bit analyze_sample(input logic signed [31:0] sp,
                                          input logic signed [31:0] cv,
                                          input bit last,
                                          output settle_report_t rep);
        logic [31:0] since_step;
        logic [63:0] dsp;
        logic [63:0] rise;
        rep = '0;
        if (primed_q)
        begin
            if (!tst_open && abs_val(longint'(sp) - longint'(last_sp)) > 64'(thr_q))
            begin
                tst_open = 1'b1;
                tst_idx = idx_q;
                tst_sp = sp;
                tst_start = last_cv;
                tst_peak = cv;
            end
            if (tst_open)
            begin
                since_step = idx_q - tst_idx;
                if (cv > tst_peak)
                    tst_peak = cv;
                if (within_band(abs_val(longint'(cv) - longint'(sp)),
                                abs_val(longint'(sp) - longint'(tst_start) + longint'(thr_q)))
                    && since_step > 32'(min_q))
                begin
                    dsp = abs_val(longint'(tst_sp) - longint'(tst_start));
                    tst_open = 1'b0;
                    hold_settle = since_step;
                    hold_ovs = (dsp > 64'(thr_q))
                        ? overshoot_q88(abs_val(longint'(tst_peak) - longint'(tst_sp)), dsp)
                        : 16'd0;
                    saw_settle = 1'b1;
                end
            end
        end
        primed_q = 1'b1;
        last_sp = sp;
        last_cv = cv;
        idx_q = idx_q + 32'd1;
        if (!last)
            return 1'b0;
        rise = 64'(hold_settle) * 64'd3;
        rep.settling = hold_settle;
        rep.rise = (rise > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rise[31:0];
        rep.overshoot = hold_ovs;
        rep.seen = saw_settle;
        clear_series();
        return 1'b1;
    endfunction

    function automatic logic signed [31:0] rand_level();
        logic signed [31:0] v;
        v = $urandom();
        if ($urandom_range(0, 2) != 0)
            v = v >>> $urandom_range(6, 26);
        return v;
    endfunction

    task automatic push_word(input logic signed [31:0] sp, input logic signed [31:0] cv,
                             input bit last, input bit pinned, input settle_report_t want);
        settle_report_t rep;
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        setpoint <= sp;
        measured <= cv;
        last_sample <= last;
        do
            @(posedge clk);
        while (in_stall);
        if (analyze_sample(sp, cv, last, rep))
            settle_reports.push_back(pinned ? want : rep);
        words_sent++;
    endtask

    // mostly damped step responses, some pure noise with stray series ends
    task automatic run_series();
        logic signed [31:0] base;
        logic signed [31:0] goal;
        longint             dev;
        int                 len;
        int                 step_at;
        int                 gain;
        int                 k;
        bit                 junk;
        junk = ($urandom_range(0, 99) < 15);
        base = rand_level();
        goal = rand_level();
        step_at = $urandom_range(1, 4);
        len = ($urandom_range(0, 19) == 0) ? 1 : step_at + min_q + $urandom_range(2, 24);
        dev = longint'(base) - longint'(goal);
        for (k = 0; k < len; k++)
        begin
            if (junk)
                push_word($urandom(), $urandom(),
                          (k == len - 1) || ($urandom_range(0, 29) == 0), 1'b0, NO_REPORT);
            else if (k < step_at)
                push_word(base, sat32(longint'(base) + (longint'($signed($urandom())) >>> 22)),
                          k == len - 1, 1'b0, NO_REPORT);
            else
            begin
                gain = $urandom_range(2, 7);
                dev = -(dev * gain) / 10;
                if ($urandom_range(0, 3) == 0)
                    dev = -dev;
                push_word(goal, sat32(longint'(goal) + dev), k == len - 1, 1'b0, NO_REPORT);
            end
        end
    endtask

    task automatic drain(input int tail);
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (settle_reports.size() != 0 && guard < 50000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (tail) @(posedge clk);
    endtask

    task automatic load_config(input logic [THR_W-1:0] thr, input logic [BAND_W-1:0] band,
                               input logic [MIN_W-1:0] min_n);
        cfg_we <= 1'b1;
        cfg_index <= REG_CHANGE_THRESHOLD;
        cfg_wdata <= CFG_DATA_W'(thr);
        @(posedge clk);
        cfg_index <= REG_BAND_FRACTION;
        cfg_wdata <= CFG_DATA_W'(band);
        @(posedge clk);
        cfg_index <= REG_MIN_SETTLE_SAMPLES;
        cfg_wdata <= CFG_DATA_W'(min_n);
        @(posedge clk);
        cfg_we <= 1'b0;
        thr_q = thr;
        band_q = band;
        min_q = min_n;
    endtask

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        settle_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (settle_reports.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, got %0d %0d %0d %0b", $time,
                         settling_samples, rise_time_tenths, overshoot_pct, settled_seen);
                mismatches++;
            end
            else
            begin
                want = settle_reports.pop_front();
                compare_field("settling_samples", want.settling, settling_samples);
                compare_field("rise_time_tenths", want.rise, rise_time_tenths);
                compare_field("overshoot_pct", 32'(want.overshoot), 32'(overshoot_pct));
                compare_field("settled_seen", 32'(want.seen), 32'(settled_seen));
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        setpoint = '0;
        measured = '0;
        last_sample = 1'b0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_CHANGE_THRESHOLD;
        cfg_wdata = '0;
        thr_q = THR_RESET;
        band_q = BAND_RESET;
        min_q = MIN_RESET;
        clear_series();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (step_script[i])
            push_word(step_script[i].sp, step_script[i].cv, step_script[i].last,
                      step_script[i].pinned, step_script[i].want);
        while (words_sent < 220)
            run_series();
        drain(DRAIN_CYCLES);

        load_config(31'd0, 16'hFFFF, 8'd0);
        idle_pct = 69;
        while (words_sent < 370)
            run_series();
        drain(1);
        while (words_sent < 520)
            run_series();
        drain(DRAIN_CYCLES);

        load_config(31'h7FFF_FFFF, 16'd0, 8'd0);
        idle_pct = 0;
        stall_pct = 69;
        while (words_sent < 700)
            run_series();
        drain(DRAIN_CYCLES);

        load_config(31'd65536, 16'd6554, 8'd255);
        idle_pct = 11;
        stall_pct = 11;
        while (words_sent < 1000)
            run_series();
        drain(DRAIN_CYCLES);

        load_config(31'($urandom_range(0, 1 << 18)), 16'($urandom_range(0, 65535)),
                    8'($urandom_range(0, 12)));
        idle_pct = 0;
        stall_pct = 0;
        while (words_sent < 1350)
            run_series();
        drain(DRAIN_CYCLES);

        if (mismatches == 0 && settle_reports.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
